[design/mrtu_pkg.sv]
// types, constants and the crc-16 byte update shared by the modbus rtu link framer
// no dependencies

package mrtu_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 9;
    localparam int unsigned CRC_W    = 16;
    localparam int unsigned MIN_FRAME = 4;
    localparam int unsigned APB_AW   = 4;
    localparam int unsigned APB_DW   = 32;
    localparam int unsigned S_USER_W = 3;
    localparam int unsigned M_DATA_W = 24;
    localparam int unsigned M_USER_W = 3;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    localparam logic [BYTE_W-1:0] OWN_ADDR_RST  = 8'd1;
    localparam logic [BYTE_W-1:0] BC_ADDR_RST   = 8'd0;
    localparam logic [BYTE_W-1:0] SILENCE_RST   = 8'd2;

    typedef enum logic [1:0] {
        REG_OWN_ADDR = 2'd0,
        REG_BC_ADDR  = 2'd1,
        REG_SILENCE  = 2'd2
    } t_reg;

    typedef enum logic [1:0] {
        CMD_RX_BYTE = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_TX_BYTE = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_LINE     = 3'd0,
        KIND_ACCEPTED = 3'd1,
        KIND_BAD_CRC  = 3'd2,
        KIND_OTHER    = 3'd3,
        KIND_SHORT    = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  line_byte;
        logic [LEN_W-1:0]   payload_length;
        logic               is_broadcast;
        logic               last;
    } t_beat;

    // reflected crc-16, one byte per call, bit loop unrolls to eight shift/xor steps
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[design/modbus_rtu_frame_link.sv]
// modbus rtu link framer: receive framing with crc check and silence timer, transmit crc append
// depends on mrtu_pkg
//
//  channel   dir  beat fields (low bit up)
//  s_axis    in   tdata: data_byte[7:0]; tuser: command[1:0], line_error[2]; tlast: tx_last
//  m_axis    out  tdata: line_byte[7:0], payload_length[16:8], is_broadcast[17], zero[23:18];
//                 tuser: kind[2:0]; tlast: last
//  apb       in   own_address @0x0, broadcast_address @0x4, silence_ticks @0x8
//
//  every input beat is handled in the cycle it is accepted: state and results are registered
//  at that edge, so one beat per cycle enters unless stalled; the byte-wide crc update sets
//  that path. results leave from a four-entry output queue, one beat per cycle unless
//  stalled; a transmit beat with tx_last gives three result beats, any other beat at most
//  one. s_axis_tready is high while at most one result waits, so a stalled output lets one
//  more input beat in before input stalls. reset is synchronous and clears all state at once.

module modbus_rtu_frame_link #(
    parameter int unsigned FRAME_MAX = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // apb configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mrtu_pkg::APB_AW-1:0]   paddr,
    input  logic [mrtu_pkg::APB_DW-1:0]   pwdata,
    output logic [mrtu_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // data_byte
    input  logic [mrtu_pkg::S_USER_W-1:0] s_axis_tuser,   // command[1:0], line_error[2]
    input  logic                          s_axis_tlast,   // tx_last
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mrtu_pkg::M_DATA_W-1:0] m_axis_tdata,   // line_byte, payload_length, is_broadcast
    output logic [mrtu_pkg::M_USER_W-1:0] m_axis_tuser,   // kind
    output logic                          m_axis_tlast    // last
);
    import mrtu_pkg::*;

    localparam int unsigned CW     = $clog2(FRAME_MAX + 1);
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QIW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    // configuration
    logic [BYTE_W-1:0] r_own_addr, r_bc_addr, r_silence;
    logic              cfg_wr;
    t_reg              cfg_sel;

    // receive and transmit state
    logic [BYTE_W-1:0] r_timer, n_timer;
    logic [CW-1:0]     r_rx_count, n_rx_count;
    logic [CRC_W-1:0]  r_rx_crc, n_rx_crc;
    logic [BYTE_W-1:0] r_dly0, n_dly0, r_dly1, n_dly1;
    logic [BYTE_W-1:0] r_faddr, n_faddr;
    logic              r_overrun, n_overrun;
    logic [CRC_W-1:0]  r_tx_crc, n_tx_crc;

    // output queue
    t_beat             r_q [QDEPTH];
    t_beat             n_q [QDEPTH];
    logic [QCW-1:0]    r_cnt, n_cnt;

    logic              in_acc, out_pop;
    t_cmd              cmd;
    logic [BYTE_W-1:0] data;
    logic              lerr;
    t_beat             beats [3];
    logic [1:0]        n_new;
    logic [QCW-1:0]    cnt_pop;
    logic [CRC_W-1:0]  tx_crc_next;
    logic [CW-1:0]     len_cnt;
    logic [BYTE_W-1:0] timer_dec;

    assign cfg_sel = t_reg'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        prdata = '0;
        case (cfg_sel)
            REG_OWN_ADDR: prdata = APB_DW'(r_own_addr);
            REG_BC_ADDR:  prdata = APB_DW'(r_bc_addr);
            REG_SILENCE:  prdata = APB_DW'(r_silence);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr <= OWN_ADDR_RST;
            r_bc_addr  <= BC_ADDR_RST;
            r_silence  <= SILENCE_RST;
        end else if (cfg_wr) begin
            case (cfg_sel)
                REG_OWN_ADDR: r_own_addr <= pwdata[BYTE_W-1:0];
                REG_BC_ADDR:  r_bc_addr  <= pwdata[BYTE_W-1:0];
                REG_SILENCE:  r_silence  <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (r_cnt < QCW'(2));
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_pop       = m_axis_tvalid && m_axis_tready;
    assign cmd           = t_cmd'(s_axis_tuser[1:0]);
    assign data          = s_axis_tdata;
    assign lerr          = s_axis_tuser[2];
    assign tx_crc_next   = crc16_byte(r_tx_crc, data);
    assign len_cnt       = (r_rx_count >= CW'(2)) ? (r_rx_count - CW'(2)) : '0;
    assign timer_dec     = r_timer - 8'd1;

    always_comb begin
        n_timer    = r_timer;
        n_rx_count = r_rx_count;
        n_rx_crc   = r_rx_crc;
        n_dly0     = r_dly0;
        n_dly1     = r_dly1;
        n_faddr    = r_faddr;
        n_overrun  = r_overrun;
        n_tx_crc   = r_tx_crc;
        n_new      = 2'd0;
        for (int j = 0; j < 3; j++) begin
            beats[j] = '{kind: KIND_LINE, line_byte: '0, payload_length: '0,
                         is_broadcast: 1'b0, last: 1'b0};
        end
        if (in_acc) begin
            case (cmd)
                CMD_RX_BYTE: begin
                    if (!lerr) begin
                        if (r_rx_count >= CW'(FRAME_MAX)) begin
                            n_overrun = 1'b1;
                        end else begin
                            if (r_rx_count == '0) begin
                                n_faddr = data;
                            end
                            // the two newest bytes are held back: they may be the crc
                            if (r_rx_count >= CW'(2)) begin
                                n_rx_crc = crc16_byte(r_rx_crc, r_dly0);
                            end
                            n_dly0     = r_dly1;
                            n_dly1     = data;
                            n_rx_count = r_rx_count + CW'(1);
                        end
                        n_timer = r_silence;
                    end
                end
                CMD_TICK: begin
                    if (r_timer != '0) begin
                        n_timer = timer_dec;
                        if (timer_dec == '0) begin
                            n_new = 2'd1;
                            beats[0].last           = 1'b1;
                            beats[0].payload_length = LEN_W'(len_cnt);
                            if (r_overrun || (r_rx_count < CW'(MIN_FRAME))) begin
                                beats[0].kind = KIND_SHORT;
                            end else if ({r_dly1, r_dly0} != r_rx_crc) begin
                                beats[0].kind = KIND_BAD_CRC;
                            end else if (r_faddr == r_own_addr) begin
                                beats[0].kind = KIND_ACCEPTED;
                            end else if (r_faddr == r_bc_addr) begin
                                beats[0].kind         = KIND_ACCEPTED;
                                beats[0].is_broadcast = 1'b1;
                            end else begin
                                beats[0].kind = KIND_OTHER;
                            end
                            n_rx_count = '0;
                            n_rx_crc   = CRC_INIT;
                            n_dly0     = '0;
                            n_dly1     = '0;
                            n_faddr    = '0;
                            n_overrun  = 1'b0;
                        end
                    end
                end
                CMD_TX_BYTE: begin
                    beats[0].line_byte = data;
                    if (s_axis_tlast) begin
                        n_new              = 2'd3;
                        beats[1].line_byte = tx_crc_next[7:0];
                        beats[2].line_byte = tx_crc_next[15:8];
                        beats[2].last      = 1'b1;
                        n_tx_crc           = CRC_INIT;
                    end else begin
                        n_new         = 2'd1;
                        beats[0].last = 1'b1;
                        n_tx_crc      = tx_crc_next;
                    end
                end
                default: ;
            endcase
        end
    end

    // queue: pop shifts the head out, new beats land behind what remains
    always_comb begin
        cnt_pop = r_cnt - QCW'(out_pop);
        for (int i = 0; i < QDEPTH; i++) begin
            n_q[i] = r_q[i];
        end
        if (out_pop) begin
            for (int i = 0; i < QDEPTH - 1; i++) begin
                n_q[i] = r_q[i + 1];
            end
        end
        for (int j = 0; j < 3; j++) begin
            if (2'(j) < n_new) begin
                n_q[QIW'(cnt_pop + QCW'(j))] = beats[j];
            end
        end
        n_cnt = cnt_pop + QCW'(n_new);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer    <= '0;
            r_rx_count <= '0;
            r_rx_crc   <= CRC_INIT;
            r_dly0     <= '0;
            r_dly1     <= '0;
            r_faddr    <= '0;
            r_overrun  <= 1'b0;
            r_tx_crc   <= CRC_INIT;
            r_cnt      <= '0;
        end else begin
            r_timer    <= n_timer;
            r_rx_count <= n_rx_count;
            r_rx_crc   <= n_rx_crc;
            r_dly0     <= n_dly0;
            r_dly1     <= n_dly1;
            r_faddr    <= n_faddr;
            r_overrun  <= n_overrun;
            r_tx_crc   <= n_tx_crc;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = {6'd0, r_q[0].is_broadcast, r_q[0].payload_length,
                            r_q[0].line_byte};
    assign m_axis_tuser  = r_q[0].kind;
    assign m_axis_tlast  = r_q[0].last;

endmodule

[test/testbench.sv]
// self-checking bench for the modbus rtu link framer: receive verdicts and transmit crc append
// depends on mrtu_pkg and modbus_rtu_frame_link; stream driver and monitor with a local predictor

module testbench;

    import mrtu_pkg::*;

    localparam int unsigned FRAME_LIMIT  = 256;
    localparam int unsigned RANDOM_ITEMS = 350;
    localparam int unsigned HOLD_PERIOD  = 1200;
    localparam int unsigned HOLD_LEN     = 120;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam logic [1:0]  REG_UNUSED   = 2'd3;

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] data;
        logic       line_err;
        logic       tx_last;
    } t_link_item;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;    // data_byte
    logic [S_USER_W-1:0]   s_axis_tuser = '0;    // command[1:0], line_error[2]
    logic                  s_axis_tlast = 1'b0;  // tx_last
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;         // line_byte[7:0], payload_length[16:8], is_broadcast[17]
    logic [M_USER_W-1:0]   m_axis_tuser;         // kind[2:0]
    logic                  m_axis_tlast;         // last

    modbus_rtu_frame_link #(.FRAME_MAX(FRAME_LIMIT)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
    );

    t_link_item pending_items[$];
    t_beat      expected_beats[$];
    int         mismatches = 0;
    int         random_items = 0;

    // predictor state
    logic [7:0]  cfg_own, cfg_bc, cfg_silence;
    logic [7:0]  silence_left;
    logic [8:0]  rx_len;
    logic [15:0] rx_crc_acc;
    logic [7:0]  crc_hold [2];
    logic [7:0]  rx_addr;
    logic        rx_over;
    logic [15:0] tx_crc_acc;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #8000000;
        $display("simulation failed");
        $finish;
    end

    // bit-serial form of the reflected crc-16
    function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] octet);
        logic [15:0] r;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            if (r[0] ^ octet[i]) r = {1'b0, r[15:1]} ^ CRC_POLY;
            else r = {1'b0, r[15:1]};
        end
        return r;
    endfunction

    function automatic t_beat make_beat(input t_kind k, input logic [7:0] lb,
                                        input logic [8:0] len, input logic bc, input logic lst);
        t_beat b;
        b.kind = k;
        b.line_byte = lb;
        b.payload_length = len;
        b.is_broadcast = bc;
        b.last = lst;
        return b;
    endfunction

    task automatic clear_rx_model;
        rx_len = '0;
        rx_crc_acc = CRC_INIT;
        crc_hold[0] = '0;
        crc_hold[1] = '0;
        rx_addr = '0;
        rx_over = 1'b0;
    endtask

    task automatic predict_link_beats(input t_link_item it);
        logic [8:0]  len;
        logic [15:0] got;
        t_kind       verdict;
        logic        bc;
        case (it.cmd)
            CMD_RX_BYTE: begin
                if (!it.line_err) begin
                    if (rx_len >= FRAME_LIMIT) begin
                        rx_over = 1'b1;
                    end else begin
                        if (rx_len == 0) rx_addr = it.data;
                        // the two newest bytes wait in the delay line, they may be the crc
                        if (rx_len >= 2) rx_crc_acc = crc16_fold(rx_crc_acc, crc_hold[0]);
                        crc_hold[0] = crc_hold[1];
                        crc_hold[1] = it.data;
                        rx_len = rx_len + 9'd1;
                    end
                    silence_left = cfg_silence;
                end
            end
            CMD_TICK: begin
                if (silence_left != 0) begin
                    silence_left = silence_left - 8'd1;
                    if (silence_left == 0) begin
                        len = (rx_len >= 2) ? rx_len - 9'd2 : 9'd0;
                        got = {crc_hold[1], crc_hold[0]};
                        bc = 1'b0;
                        if (rx_over || rx_len < MIN_FRAME) verdict = KIND_SHORT;
                        else if (got != rx_crc_acc) verdict = KIND_BAD_CRC;
                        else if (rx_addr == cfg_own) verdict = KIND_ACCEPTED;
                        else if (rx_addr == cfg_bc) begin
                            verdict = KIND_ACCEPTED;
                            bc = 1'b1;
                        end else verdict = KIND_OTHER;
                        expected_beats.push_back(make_beat(verdict, 8'h00, len, bc, 1'b1));
                        clear_rx_model();
                    end
                end
            end
            CMD_TX_BYTE: begin
                tx_crc_acc = crc16_fold(tx_crc_acc, it.data);
                if (!it.tx_last) begin
                    expected_beats.push_back(make_beat(KIND_LINE, it.data, 9'd0, 1'b0, 1'b1));
                end else begin
                    expected_beats.push_back(make_beat(KIND_LINE, it.data, 9'd0, 1'b0, 1'b0));
                    expected_beats.push_back(make_beat(KIND_LINE, tx_crc_acc[7:0], 9'd0,
                                                       1'b0, 1'b0));
                    expected_beats.push_back(make_beat(KIND_LINE, tx_crc_acc[15:8], 9'd0,
                                                       1'b0, 1'b1));
                    tx_crc_acc = CRC_INIT;
                end
            end
            default: ;
        endcase
    endtask

    // driver: bursts of beats with random gaps
    t_link_item offered;
    int         burst_left = 0;
    int         idle_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_link_beats(offered);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (idle_left > 0) begin
                    idle_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    offered = pending_items.pop_front();
                    s_axis_tdata <= offered.data;
                    s_axis_tuser <= {offered.line_err, offered.cmd};
                    s_axis_tlast <= offered.tx_last;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 20);
                        idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: changing stall pattern plus a periodic long hold-off
    int rx_cycle = 0;
    int stall_mode = 0;
    int hold_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle % 50 == 0) stall_mode = $urandom_range(0, 3);
            if (rx_cycle % HOLD_PERIOD == HOLD_PERIOD / 2) hold_left = HOLD_LEN;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= rx_cycle[1];
                endcase
            end
        end
    end

    // monitor
    t_beat seen, want;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = make_beat(t_kind'(m_axis_tuser[2:0]), m_axis_tdata[7:0], m_axis_tdata[16:8],
                             m_axis_tdata[17], m_axis_tlast);
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: kind %0d byte %02h len %0d bc %0b last %0b",
                             seen.kind, seen.line_byte, seen.payload_length, seen.is_broadcast,
                             seen.last);
            end else begin
                want = expected_beats.pop_front();
                if (seen !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: expected kind %0d byte %02h len %0d bc %0b",
                                  " last %0b, got kind %0d byte %02h len %0d bc %0b last %0b"},
                                 want.kind, want.line_byte, want.payload_length,
                                 want.is_broadcast, want.last, seen.kind, seen.line_byte,
                                 seen.payload_length, seen.is_broadcast, seen.last);
                end
            end
        end
    end

    task automatic push_item(input logic [1:0] cmd, input logic [7:0] data, input logic err,
                             input logic last, input bit counts);
        t_link_item it;
        it.cmd = cmd;
        it.data = data;
        it.line_err = err;
        it.tx_last = last;
        pending_items.push_back(it);
        if (counts) random_items++;
    endtask

    task automatic push_ticks(input int n);
        for (int i = 0; i < n; i++)
            push_item(CMD_TICK, 8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
    endtask

    task automatic push_tx_message(input int n);
        for (int i = 0; i < n; i++)
            push_item(CMD_TX_BYTE, 8'($urandom), 1'($urandom), i == n - 1, 1'b1);
    endtask

    // address, body bytes (function code first), then crc low and high
    task automatic push_frame(input logic [7:0] addr, input int body, input bit crc_ok,
                              input bit noisy);
        logic [7:0]  bytes[$];
        logic [15:0] crc;
        bytes.push_back(addr);
        for (int i = 0; i < body; i++) bytes.push_back(8'($urandom));
        crc = CRC_INIT;
        foreach (bytes[i]) crc = crc16_fold(crc, bytes[i]);
        if (!crc_ok) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        bytes.push_back(crc[7:0]);
        bytes.push_back(crc[15:8]);
        foreach (bytes[i]) begin
            // errored bytes are dropped, transmit beats run alongside
            if (noisy && $urandom_range(0, 9) == 0)
                push_item(CMD_RX_BYTE, 8'($urandom), 1'b1, 1'($urandom), 1'b0);
            if (noisy && $urandom_range(0, 11) == 0)
                push_item(CMD_TX_BYTE, 8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
            push_item(CMD_RX_BYTE, bytes[i], 1'b0, 1'($urandom), 1'b1);
        end
    endtask

    task automatic apb_write(input logic [1:0] reg_index, input logic [7:0] value);
        logic [31:0] word;
        word = $urandom;
        word[7:0] = value;
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_index, 2'b00};
        pwdata <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (reg_index)
            REG_OWN_ADDR: cfg_own = value;
            REG_BC_ADDR:  cfg_bc = value;
            REG_SILENCE:  cfg_silence = value;
            default: ;
        endcase
    endtask

    task automatic drain_link;
        @(negedge i_clk);
        while (pending_items.size() != 0 || s_axis_tvalid || expected_beats.size() != 0)
            @(negedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [7:0] own, input logic [7:0] bc,
                                input logic [7:0] silence);
        apb_write(REG_OWN_ADDR, own);
        apb_write(REG_BC_ADDR, bc);
        apb_write(REG_SILENCE, silence);
    endtask

    initial begin
        int         pick;
        int         phase_start;
        logic [7:0] addr;
        cfg_own = OWN_ADDR_RST;
        cfg_bc = BC_ADDR_RST;
        cfg_silence = SILENCE_RST;
        silence_left = '0;
        tx_crc_acc = CRC_INIT;
        clear_rx_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: idle tick, unused command, transmit extremes, basic frames
        push_item(CMD_TICK, 8'hA5, 1'b1, 1'b1, 1'b0);
        push_item(CMD_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b0);
        push_item(CMD_TX_BYTE, 8'h00, 1'b0, 1'b0, 1'b0);
        push_item(CMD_TX_BYTE, 8'hFF, 1'b1, 1'b1, 1'b0);
        push_frame(OWN_ADDR_RST, 1, 1'b1, 1'b0);
        push_ticks(2);
        push_item(CMD_RX_BYTE, 8'h3C, 1'b1, 1'b0, 1'b0);
        push_frame(BC_ADDR_RST, 1, 1'b1, 1'b0);
        push_ticks(2);
        push_item(CMD_RX_BYTE, 8'h01, 1'b0, 1'b0, 1'b0);
        push_ticks(2);
        drain_link();

        // own equals broadcast, bad crc on a foreign address, foreign address
        write_config(8'd5, 8'd5, 8'd1);
        apb_write(REG_UNUSED, 8'h77);
        push_frame(8'd5, 1, 1'b1, 1'b0);
        push_ticks(1);
        push_frame(8'h22, 1, 1'b0, 1'b0);
        push_ticks(1);
        push_frame(8'h22, 1, 1'b1, 1'b0);
        push_ticks(1);
        drain_link();

        // zero silence leaves the timer idle until a later byte
        apb_write(REG_SILENCE, 8'd0);
        push_frame(cfg_own, 2, 1'b1, 1'b0);
        push_ticks(3);
        drain_link();
        apb_write(REG_SILENCE, 8'd3);
        push_item(CMD_RX_BYTE, 8'h5A, 1'b0, 1'b0, 1'b0);
        push_ticks(3);
        drain_link();

        // top register values
        write_config(8'd247, 8'd255, 8'd255);
        push_frame(8'd255, 3, 1'b1, 1'b0);
        push_ticks(255);
        push_tx_message(3);
        drain_link();

        // full frame, then two bytes past the limit
        write_config(8'd1, 8'd0, 8'd1);
        push_frame(8'd1, FRAME_LIMIT - 3, 1'b1, 1'b0);
        push_ticks(1);
        push_frame(8'd0, FRAME_LIMIT - 1, 1'b1, 1'b0);
        push_ticks(1);
        drain_link();

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            drain_link();
            addr = 8'($urandom_range(1, 247));
            write_config(addr, ($urandom_range(0, 3) == 0) ? addr : 8'($urandom_range(0, 255)),
                         ($urandom_range(0, 4) == 0) ? 8'd1 : 8'($urandom_range(2, 5)));
            phase_start = random_items;
            while (random_items - phase_start < 70) begin
                pick = $urandom_range(0, 99);
                case ($urandom_range(0, 3))
                    0, 1: addr = cfg_own;
                    2: addr = cfg_bc;
                    default: addr = 8'($urandom);
                endcase
                if (pick < 50) begin
                    push_frame(addr, $urandom_range(1, 10), 1'b1, 1'b1);
                    push_ticks(int'(cfg_silence));
                end else if (pick < 60) begin
                    push_frame(addr, $urandom_range(1, 10), 1'b0, 1'b1);
                    push_ticks(int'(cfg_silence));
                end else if (pick < 68) begin
                    repeat ($urandom_range(1, 3))
                        push_item(CMD_RX_BYTE, 8'($urandom), 1'b0, 1'($urandom), 1'b1);
                    push_ticks(int'(cfg_silence));
                end else if (pick < 85) begin
                    push_tx_message($urandom_range(1, 6));
                end else begin
                    repeat ($urandom_range(1, 4))
                        push_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                                  1'($urandom), 1'b0);
                end
                if ($urandom_range(0, 3) == 0)
                    push_item(CMD_TICK, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0);
            end
        end

        drain_link();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
